FILE: rtl/core/pds_pkg.sv
// Package for the PLL divider search block: payload types, state codes and constants.
// No dependencies; used by the other files in rtl/core except pds_divider.
package pds_pkg;

    localparam int MAX_PRE_DIV_DEF  = 63;
    localparam int MAX_MULT_DEF     = 512;
    localparam int MAX_POST_DIV_DEF = 128;

    localparam logic [29:0] REF_MIN  = 30'd1000000;
    localparam logic [29:0] REF_MAX  = 30'd16000000;
    localparam logic [29:0] VCO_MIN  = 30'd150000000;
    localparam logic [29:0] VCO_MAX  = 30'd836000000;
    localparam int          MULT_MIN = 4;

    typedef struct packed {
        logic [29:0] source_hz;
        logic [29:0] target_p_hz;
        logic [29:0] target_q_hz;
        logic [29:0] target_r_hz;
        logic        p_even_only;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [5:0] pre_divider;
        logic [9:0] multiplier;
        logic [7:0] p_divider;
        logic [7:0] q_divider;
        logic [7:0] r_divider;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REF_DIV,
        ST_REF_CHK,
        ST_VCO,
        ST_VCO_CHK,
        ST_DIV,
        ST_NEXT_N,
        ST_NEXT_M,
        ST_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic m_init;
        logic m_inc;
        logic div_start;
        logic n_init;
        logic n_inc;
        logic vco_calc;
        logic d_init;
        logic d_step;
        logic hit;
        logic out_clr;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic div_busy;
        logic ref_ok;
        logic vco_ok;
        logic m_last;
        logic n_last;
        logic d_last;
        logic all_met;
    } sts_t;

endpackage

FILE: rtl/core/pll_divider_search.sv
// PLL divider search handles one request at a time. For each pre-divider m a serial
// divider forms the reference; each kept multiplier n then runs divider trials (up to
// MAX_POST_DIV), with P, Q and R tried in parallel. The result is held until the
// transfer on the m_ channel completes.
module pll_divider_search #(
    parameter int MAX_PRE_DIV  = pds_pkg::MAX_PRE_DIV_DEF,
    parameter int MAX_MULT     = pds_pkg::MAX_MULT_DEF,
    parameter int MAX_POST_DIV = pds_pkg::MAX_POST_DIV_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pds_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pds_pkg::rsp_t m_data
);

    pds_pkg::cmd_t cmd;
    pds_pkg::sts_t sts;

    pds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pds_datapath #(
        .MAX_PRE_DIV  (MAX_PRE_DIV),
        .MAX_MULT     (MAX_MULT),
        .MAX_POST_DIV (MAX_POST_DIV)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (m_data)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while a result is pending");
    a_found_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.pre_divider == 6'd0
        && m_data.multiplier == 10'd0)) else $error("dividers set without a hit");
    a_hit_m: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> (m_data.pre_divider != 6'd0))
        else $error("hit with zero pre-divider");

endmodule

FILE: rtl/core/pds_divider.sv
// Restoring serial divider, one quotient bit per cycle: 30-bit by 8-bit.
// Does not use pds_pkg.
module pds_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [7:0]  divisor,
    output logic        busy,
    output logic [29:0] quotient
);

    logic [29:0] quot_reg, quot_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[7:0], quot_reg[29]};
        if (start) begin
            quot_next = dividend;
            rem_next  = 9'd0;
            dsr_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = trial - {1'b0, dsr_reg};
                quot_next = {quot_reg[28:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[28:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/core/pds_datapath.sv
// Datapath of the PLL divider search: counters, reference and VCO values, divider trials.
// Depends on pds_pkg and pds_divider.
module pds_datapath #(
    parameter int MAX_PRE_DIV  = pds_pkg::MAX_PRE_DIV_DEF,
    parameter int MAX_MULT     = pds_pkg::MAX_MULT_DEF,
    parameter int MAX_POST_DIV = pds_pkg::MAX_POST_DIV_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pds_pkg::req_t  req,
    input  pds_pkg::cmd_t  cmd,
    output pds_pkg::sts_t  sts,
    output pds_pkg::rsp_t  rsp
);

    localparam int MW = $clog2(MAX_PRE_DIV + 1);
    localparam int NW = $clog2(MAX_MULT + 1);

    pds_pkg::req_t   req_reg;
    logic [MW-1:0]   m_reg;
    logic [NW-1:0]   n_reg;
    logic [8:0]      d_reg;
    logic [29:0]     ref_reg;
    logic [39:0]     vco_reg;
    logic [29:0]     quot;
    logic            div_busy;
    logic            p_reg, q_reg, r_reg;
    logic [7:0]      pd_reg, qd_reg, rd_reg;
    pds_pkg::rsp_t   rsp_reg;
    logic [29:0]     vco30;
    logic [38:0]     pq, qq, rq;
    logic [8:0]      d_p;

    pds_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (req_reg.source_hz),
        .divisor  (8'(m_reg)),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign vco30 = vco_reg[29:0];

    // floor(vco/d) == t  <=>  t*d <= vco < (t+1)*d ; P uses its own trial value.
    assign d_p = req_reg.p_even_only ? {d_reg[7:0], 1'b0} : d_reg + 9'd1;
    always_comb begin
        pq = 39'(req_reg.target_p_hz) * 39'(d_p);
        qq = 39'(req_reg.target_q_hz) * 39'(d_reg);
        rq = 39'(req_reg.target_r_hz) * 39'(d_reg);
    end

    function automatic logic hit_of(input logic [38:0] td, input logic [8:0] d,
                                    input logic [29:0] v);
        logic [39:0] up;
        begin
            up = 40'(td) + 40'(d);
            hit_of = (td <= 39'(v)) && (40'(v) < up);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req;
        end
        if (cmd.m_init) begin
            m_reg <= MW'(1);
        end else if (cmd.m_inc) begin
            m_reg <= m_reg + MW'(1);
        end
        if (!div_busy) begin
            ref_reg <= quot;
        end
        if (cmd.n_init) begin
            n_reg <= NW'(pds_pkg::MULT_MIN);
        end else if (cmd.n_inc) begin
            n_reg <= n_reg + NW'(1);
        end
        if (cmd.vco_calc) begin
            vco_reg <= 40'(ref_reg) * 40'(n_reg);
        end
        if (cmd.d_init) begin
            d_reg  <= 9'd1;
            p_reg  <= (req_reg.target_p_hz == 30'd0);
            q_reg  <= (req_reg.target_q_hz == 30'd0);
            r_reg  <= (req_reg.target_r_hz == 30'd0);
            pd_reg <= 8'd0;
            qd_reg <= 8'd0;
            rd_reg <= 8'd0;
        end else if (cmd.d_step) begin
            d_reg <= d_reg + 9'd1;
            if (!p_reg && (32'(d_p) <= MAX_POST_DIV) && hit_of(pq, d_p, vco30)) begin
                p_reg  <= 1'b1;
                pd_reg <= d_p[7:0];
            end
            if (!q_reg && hit_of(qq, d_reg, vco30)) begin
                q_reg  <= 1'b1;
                qd_reg <= d_reg[7:0];
            end
            if (!r_reg && hit_of(rq, d_reg, vco30)) begin
                r_reg  <= 1'b1;
                rd_reg <= d_reg[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_clr) begin
            rsp_reg <= '0;
        end else if (cmd.hit) begin
            rsp_reg.found       <= 1'b1;
            rsp_reg.pre_divider <= 6'(m_reg);
            rsp_reg.multiplier  <= 10'(n_reg);
            rsp_reg.p_divider   <= pd_reg;
            rsp_reg.q_divider   <= qd_reg;
            rsp_reg.r_divider   <= rd_reg;
        end
    end

    // The reference is checked straight from the divider output, in the cycle it settles.
    assign sts.div_busy = div_busy;
    assign sts.ref_ok   = (quot >= pds_pkg::REF_MIN) && (quot <= pds_pkg::REF_MAX);
    assign sts.vco_ok   = (vco_reg >= 40'(pds_pkg::VCO_MIN))
                          && (vco_reg <= 40'(pds_pkg::VCO_MAX));
    assign sts.m_last   = (32'(m_reg) >= MAX_PRE_DIV);
    assign sts.n_last   = (32'(n_reg) >= MAX_MULT);
    assign sts.d_last   = (32'(d_reg) > MAX_POST_DIV);
    assign sts.all_met  = p_reg && q_reg && r_reg;
    assign rsp          = rsp_reg;

endmodule

FILE: rtl/core/pds_ctrl.sv
// Controller state machine of the PLL divider search.
// Depends on pds_pkg.
module pds_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  pds_pkg::sts_t sts,
    output pds_pkg::cmd_t cmd
);

    pds_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pds_pkg::ST_IDLE:    if (s_valid) state_next = pds_pkg::ST_REF_DIV;
            pds_pkg::ST_REF_DIV: state_next = pds_pkg::ST_REF_CHK;
            pds_pkg::ST_REF_CHK: begin
                if (!sts.div_busy) begin
                    state_next = sts.ref_ok ? pds_pkg::ST_VCO : pds_pkg::ST_NEXT_M;
                end
            end
            pds_pkg::ST_VCO:     state_next = pds_pkg::ST_VCO_CHK;
            pds_pkg::ST_VCO_CHK: state_next = sts.vco_ok ? pds_pkg::ST_DIV : pds_pkg::ST_NEXT_N;
            pds_pkg::ST_DIV: begin
                if (sts.all_met) begin
                    state_next = pds_pkg::ST_DONE;
                end else if (sts.d_last) begin
                    state_next = pds_pkg::ST_NEXT_N;
                end
            end
            pds_pkg::ST_NEXT_N:  state_next = sts.n_last ? pds_pkg::ST_NEXT_M : pds_pkg::ST_VCO;
            pds_pkg::ST_NEXT_M:  state_next = sts.m_last ? pds_pkg::ST_DONE : pds_pkg::ST_REF_DIV;
            pds_pkg::ST_DONE:    if (m_ready) state_next = pds_pkg::ST_IDLE;
            default:             state_next = pds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            pds_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.m_init  = s_valid;
                cmd.out_clr = s_valid;
            end
            pds_pkg::ST_REF_DIV: cmd.div_start = 1'b1;
            pds_pkg::ST_REF_CHK: cmd.n_init = 1'b1;
            pds_pkg::ST_VCO:     cmd.vco_calc = 1'b1;
            pds_pkg::ST_VCO_CHK: cmd.d_init = 1'b1;
            pds_pkg::ST_DIV: begin
                cmd.hit    = sts.all_met;
                cmd.d_step = !sts.all_met && !sts.d_last;
            end
            pds_pkg::ST_NEXT_N:  cmd.n_inc = 1'b1;
            pds_pkg::ST_NEXT_M:  cmd.m_inc = 1'b1;
            pds_pkg::ST_DONE:    m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pds_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for pll_divider_search: directed and random divider searches.
// Depends on pds_pkg and the pll_divider_search RTL; predicts each result independently.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pds_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 20000000;
    localparam int RANDOM_PER_PHASE = 33;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_data;

    rsp_t  expected_settings[$];
    int    send_gap_pct = 0;
    int    recv_stall_pct = 0;
    int    mismatches = 0;
    int    requests_sent = 0;
    int    solutions_seen = 0;
    int    results_seen = 0;
    longint unsigned cycle_count = 0;

    pll_divider_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded cycle limit", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Smallest divider from first upward (even steps if asked) whose truncated
    // quotient of the VCO equals the target; zero when none fits.
    function automatic int smallest_divider(longint unsigned vco, longint unsigned target,
                                            int first, bit even);
        longint unsigned lo, hi, d;
        lo = vco / (target + 1) + 1;
        hi = vco / target;
        d = (lo < first) ? first : lo;
        if (even && d[0])
            d++;
        if (d > hi || d > MAX_POST_DIV_DEF)
            return 0;
        return int'(d);
    endfunction

    function automatic rsp_t predict_dividers(req_t r);
        longint unsigned src, refc, vco;
        int p, q, rd;
        rsp_t o;
        o = '0;
        src = r.source_hz;
        for (int m = 1; m <= MAX_PRE_DIV_DEF; m++) begin
            refc = src / m;
            if (refc < REF_MIN || refc > REF_MAX)
                continue;
            for (int n = MULT_MIN; n <= MAX_MULT_DEF; n++) begin
                vco = refc * n;
                p = 0;
                q = 0;
                rd = 0;
                if (vco < VCO_MIN || vco > VCO_MAX)
                    continue;
                if (r.target_p_hz != 0) begin
                    p = smallest_divider(vco, r.target_p_hz, 2, r.p_even_only);
                    if (p == 0)
                        continue;
                end
                if (r.target_q_hz != 0) begin
                    q = smallest_divider(vco, r.target_q_hz, 1, 1'b0);
                    if (q == 0)
                        continue;
                end
                if (r.target_r_hz != 0) begin
                    rd = smallest_divider(vco, r.target_r_hz, 1, 1'b0);
                    if (rd == 0)
                        continue;
                end
                o.found = 1'b1;
                o.pre_divider = m[5:0];
                o.multiplier = n[9:0];
                o.p_divider = p[7:0];
                o.q_divider = q[7:0];
                o.r_divider = rd[7:0];
                return o;
            end
        end
        return o;
    endfunction

    // Builds targets that are met a few multipliers past the first usable one,
    // so the search ends early. Sources with no usable pre-divider get random targets.
    function automatic req_t make_reachable_request(logic [29:0] src);
        req_t r;
        longint unsigned refc, vco;
        int m0, n0, n;
        r = '0;
        r.source_hz = src;
        r.p_even_only = 1'($urandom_range(0, 1));
        m0 = 0;
        for (int m = MAX_PRE_DIV_DEF; m >= 1; m--) begin
            refc = src / m;
            if (refc >= REF_MIN && refc <= REF_MAX)
                m0 = m;
        end
        if (m0 == 0) begin
            r.target_p_hz = 30'($urandom);
            r.target_q_hz = 30'($urandom);
            r.target_r_hz = 30'($urandom);
            return r;
        end
        refc = src / m0;
        n0 = int'((VCO_MIN + refc - 1) / refc);
        if (n0 < MULT_MIN)
            n0 = MULT_MIN;
        n = n0 + $urandom_range(0, 15);
        if (n > MAX_MULT_DEF || refc * n > VCO_MAX)
            n = n0;
        vco = refc * n;
        if ($urandom_range(0, 4) != 0)
            r.target_p_hz = r.p_even_only ? 30'(vco / (2 * $urandom_range(1, 64)))
                                          : 30'(vco / $urandom_range(2, 128));
        if ($urandom_range(0, 4) != 0)
            r.target_q_hz = 30'(vco / $urandom_range(1, 128));
        if ($urandom_range(0, 4) != 0)
            r.target_r_hz = 30'(vco / $urandom_range(1, 128));
        return r;
    endfunction

    task automatic send_request(req_t r);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_settings.push_back(predict_dividers(r));
        requests_sent++;
    endtask

    // Checks each result transfer and then decides the next ready value.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_settings.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                mismatches++;
            end else begin
                want = expected_settings.pop_front();
                if (m_data.found !== want.found || m_data.pre_divider !== want.pre_divider ||
                    m_data.multiplier !== want.multiplier ||
                    m_data.p_divider !== want.p_divider ||
                    m_data.q_divider !== want.q_divider ||
                    m_data.r_divider !== want.r_divider) begin
                    $display("%0t: expected %p, got %p", $time, want, m_data);
                    mismatches++;
                end
                if (m_data.found === 1'b1)
                    solutions_seen++;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic req_t build_request(logic [29:0] src, logic [29:0] tp, logic [29:0] tq,
                                           logic [29:0] tr, logic even);
        req_t r;
        r.source_hz = src;
        r.target_p_hz = tp;
        r.target_q_hz = tq;
        r.target_r_hz = tr;
        r.p_even_only = even;
        return r;
    endfunction

    task automatic test_directed();
        // Sources too low, zero and too high leave no pre-divider.
        send_request(build_request(30'd0, 30'd0, 30'd0, 30'd0, 1'b0));
        send_request(build_request(30'd999999, 30'd100000000, 30'd0, 30'd0, 1'b0));
        send_request(build_request('1, '1, '1, '1, 1'b1));
        // VCO at its top bound with undivided Q and R.
        send_request(build_request(30'd2000000, 30'd418000000, 30'd836000000,
                                   30'd836000000, 1'b1));
        // A large source, every target unused.
        send_request(build_request(30'd1000000000, 30'd0, 30'd0, 30'd0, 1'b0));
        // A single usable pre-divider with unreachable targets: full miss.
        send_request(build_request(30'd1500000, '1, '1, '1, 1'b0));
        // Largest divider on P, unit divider on Q.
        send_request(build_request(30'd16000000, 30'd1250000, 30'd160000000, 30'd0, 1'b1));
        send_request(build_request(30'd16000000, 30'd80000000, 30'd0, 30'd1, 1'b1));
        send_request(build_request(30'd25000000, 30'd0, 30'd0, 30'd0, 1'b0));
        send_request(build_request(30'd8000000, 30'd76000000, 30'd0, 30'd50666666, 1'b0));
        for (int i = 0; i < 8; i++)
            send_request(make_reachable_request(30'($urandom_range(1000000, 1000000000))));
    endtask

    task automatic test_random(int gap_pct, int stall_pct);
        logic [29:0] src;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            case ($urandom_range(0, 9))
                0: src = 30'($urandom_range(0, 999999));
                1: src = 30'($urandom_range(1008000001, 30'h3FFFFFFF));
                default: src = 30'($urandom_range(1000000, 1000000000));
            endcase
            send_request(make_reachable_request(src));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(36, 67);
        test_random(67, 36);
        test_random(0, 0);
        s_valid <= 1'b0;
        while (expected_settings.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d search requests, checked %0d results, %0d with a divider set.",
                 requests_sent, results_seen, solutions_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
